/* hdl/fbc_pkg.sv */
// shared types and codes for the frustum block cull
`timescale 1ns / 1ps

package fbc_pkg;

    // item kinds
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_BLOCK  = 2'd1;
    localparam logic [1:0] KIND_VERTEX = 2'd2;

    // number of coefficients per plane (a, b, c, d)
    localparam int NUM_COEFS = 4;

    // coefficient lanes within a plane row
    localparam int LANE_A = 0;
    localparam int LANE_B = 1;
    localparam int LANE_C = 2;
    localparam int LANE_D = 3;

    // number of block corners
    localparam int NUM_CORNERS = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_WAIT,
        ST_HOLD
    } state_t;

    // tag that follows one plane row down the evaluation pipe
    typedef struct packed {
        logic vld;
        logic last;
    } eval_tag_t;

    // evaluation result handed back to the controller
    typedef struct packed {
        logic done;
        logic hit;
    } eval_res_t;

endpackage

/* hdl/fbc_plane_mem.sv */
// plane coefficient store: one row per plane, one lane per coefficient
`timescale 1ns / 1ps

module fbc_plane_mem
    import fbc_pkg::*;
#(
    parameter int NUM_PLANES = 6,
    parameter int KW         = 32,
    parameter int PW         = 3
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [PW-1:0]                   wr_plane,
    input  logic [1:0]                      wr_coef,
    input  logic [KW-1:0]                   wr_data,
    input  logic                            rd_en,
    input  logic [PW-1:0]                   rd_plane,
    output logic [NUM_COEFS-1:0][KW-1:0]    rd_row
);

    logic [NUM_COEFS-1:0][KW-1:0] mem [NUM_PLANES];
    logic [NUM_COEFS-1:0]         lane_vld_reg [NUM_PLANES];
    logic [NUM_COEFS-1:0][KW-1:0] rd_data_reg;
    logic [NUM_COEFS-1:0]         rd_vld_reg;

    // lane write, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_plane][wr_coef] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_plane];
        end
    end

    // written-since-reset flags, an unwritten lane reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                lane_vld_reg[p] <= '0;
            end
            rd_vld_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                lane_vld_reg[wr_plane][wr_coef] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= lane_vld_reg[rd_plane];
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_COEFS; l++)
        begin
            rd_row[l] = rd_vld_reg[l] ? rd_data_reg[l] : '0;
        end
    end

endmodule

/* hdl/fbc_plane_eval.sv */
// plane evaluation pipe: products, base sum and corner offsets, sign test
`timescale 1ns / 1ps

module fbc_plane_eval
    import fbc_pkg::*;
#(
    parameter int KW = 32,
    parameter int CW = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic                            is_vertex,
    input  logic signed [CW-1:0]            pos_x,
    input  logic signed [CW-1:0]            pos_y,
    input  logic signed [CW-1:0]            pos_z,
    input  eval_tag_t                       row_tag,
    input  logic [NUM_COEFS-1:0][KW-1:0]    row,
    output eval_res_t                       res
);

    localparam int PRW = KW + CW;
    localparam int SW  = KW + CW + 4;

    logic signed [KW-1:0]  coef_a;
    logic signed [KW-1:0]  coef_b;
    logic signed [KW-1:0]  coef_c;
    logic signed [KW-1:0]  coef_d;
    logic signed [PRW-1:0] prod_x_next;
    logic signed [PRW-1:0] prod_y_next;
    logic signed [PRW-1:0] prod_z_next;

    logic signed [PRW-1:0] prod_x_reg;
    logic signed [PRW-1:0] prod_y_reg;
    logic signed [PRW-1:0] prod_z_reg;
    logic signed [KW-1:0]  a_reg;
    logic signed [KW-1:0]  b_reg;
    logic signed [KW-1:0]  c_reg;
    logic signed [KW-1:0]  d_reg;
    eval_tag_t             tag_a_reg;

    logic signed [SW-1:0]  base_next;
    logic signed [SW-1:0]  off_next [NUM_CORNERS];
    logic signed [SW-1:0]  base_reg;
    logic signed [SW-1:0]  off_reg [NUM_CORNERS];
    eval_tag_t             tag_b_reg;

    logic signed [SW-1:0]  corner_sum [NUM_CORNERS];
    logic [NUM_CORNERS-1:0] pass;
    logic [NUM_CORNERS-1:0] alive_reg;
    logic [NUM_CORNERS-1:0] alive_next;
    eval_res_t             res_reg;
    eval_res_t             res_next;

    assign coef_a = row[LANE_A];
    assign coef_b = row[LANE_B];
    assign coef_c = row[LANE_C];
    assign coef_d = row[LANE_D];

    // stage a: three multiplies against the center
    assign prod_x_next = coef_a * pos_x;
    assign prod_y_next = coef_b * pos_y;
    assign prod_z_next = coef_c * pos_z;

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x_next;
        prod_y_reg <= prod_y_next;
        prod_z_reg <= prod_z_next;
        a_reg      <= coef_a;
        b_reg      <= coef_b;
        c_reg      <= coef_c;
        d_reg      <= coef_d;
    end

    // stage b: base sum and the eight +-a +-b +-c offsets
    always_comb
    begin
        logic [2:0] kb;
        kb        = '0;
        base_next = SW'(prod_x_reg) + SW'(prod_y_reg) + SW'(prod_z_reg) + SW'(d_reg);
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            kb          = 3'(k);
            off_next[k] = (kb[2] ? SW'(a_reg) : -SW'(a_reg))
                        + (kb[1] ? SW'(b_reg) : -SW'(b_reg))
                        + (kb[0] ? SW'(c_reg) : -SW'(c_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            off_reg[k] <= off_next[k];
        end
    end

    // stage c: sign test per corner, a vertex uses the base alone
    always_comb
    begin
        for (int k = 0; k < NUM_CORNERS; k++)
        begin
            corner_sum[k] = is_vertex ? base_reg : base_reg + off_reg[k];
            pass[k]       = corner_sum[k] > 0;
        end
        alive_next = alive_reg;
        res_next   = '0;
        if (start)
        begin
            alive_next = '1;
        end
        else if (tag_b_reg.vld)
        begin
            alive_next    = alive_reg & pass;
            res_next.done = tag_b_reg.last;
            res_next.hit  = |(alive_reg & pass);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_a_reg <= '0;
            tag_b_reg <= '0;
            alive_reg <= '0;
            res_reg   <= '0;
        end
        else
        begin
            tag_a_reg <= row_tag;
            tag_b_reg <= tag_a_reg;
            alive_reg <= alive_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

endmodule

/* hdl/frustum_block_cull.sv */
// frustum block cull top level: item decode, plane sweep control, result register
//
// input channel (in_valid / in_stall) carries one item per beat: kind 0 loads
// one plane coefficient, kind 1 tests a block (eight corners at center +-1),
// kind 2 tests a single vertex, kind 3 is dropped. loads and dropped items
// do not raise in_stall and give no result. a test sweeps the plane store one
// plane row per cycle through a three-stage multiply / sum / sign-test pipe,
// and in_stall stays high while the sweep and its result are in progress.
// the output channel (out_valid / out_stall) gives one inside_res beat per
// test. the result sits in its own register, so loads are still taken while
// it waits; a test that finishes while the register is full parks its result
// and holds in_stall high until the receiver takes the waiting beat.
// reset clears the control state and the coefficient written flags, so every
// plane reads as all zero and every test reports outside until loaded.
`timescale 1ns / 1ps

module frustum_block_cull
    import fbc_pkg::*;
#(
    parameter int NUM_PLANES  = 6,
    parameter int COORD_WIDTH = 16,
    parameter int COEF_WIDTH  = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [2:0]         plane_index,
    input  logic [1:0]         coef_index,
    input  logic signed [31:0] coef_value,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic signed [15:0] pos_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               inside_res
);

    // coefficients keep at most 32 bits, coordinates at most 16
    localparam int KW = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
    localparam int CW = (COORD_WIDTH < 16) ? COORD_WIDTH : 16;
    localparam int PW = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    state_t                       state_reg;
    state_t                       state_next;
    logic [PW-1:0]                plane_reg;
    logic [PW-1:0]                plane_next;
    logic signed [CW-1:0]         x_reg;
    logic signed [CW-1:0]         y_reg;
    logic signed [CW-1:0]         z_reg;
    logic                         vertex_reg;
    logic                         pend_reg;
    logic                         pend_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         inside_reg;
    logic                         inside_next;
    eval_tag_t                    rd_tag_reg;
    eval_tag_t                    issue_tag;

    logic                         in_fire;
    logic                         out_free;
    logic                         is_test;
    logic                         start;
    logic                         wr_en;
    logic                         rd_en;
    logic [NUM_COEFS-1:0][KW-1:0] rd_row;
    eval_res_t                    res;

    assign in_fire  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign is_test  = (kind == KIND_BLOCK) || (kind == KIND_VERTEX);
    assign start    = in_fire && is_test;

    // loads to a plane past the configured count are dropped
    assign wr_en = in_fire && (kind == KIND_LOAD) && (int'(plane_index) < NUM_PLANES);

    fbc_plane_mem #(
        .NUM_PLANES (NUM_PLANES),
        .KW         (KW),
        .PW         (PW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_plane (plane_index[PW-1:0]),
        .wr_coef  (coef_index),
        .wr_data  (coef_value[KW-1:0]),
        .rd_en    (rd_en),
        .rd_plane (plane_reg),
        .rd_row   (rd_row)
    );

    fbc_plane_eval #(
        .KW (KW),
        .CW (CW)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .is_vertex (vertex_reg),
        .pos_x     (x_reg),
        .pos_y     (y_reg),
        .pos_z     (z_reg),
        .row_tag   (rd_tag_reg),
        .row       (rd_row),
        .res       (res)
    );

    // operand capture for a test
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg      <= pos_x[CW-1:0];
            y_reg      <= pos_y[CW-1:0];
            z_reg      <= pos_z[CW-1:0];
            vertex_reg <= (kind == KIND_VERTEX);
        end
    end

    // read issue: one plane row per cycle while sweeping
    always_comb
    begin
        rd_en          = (state_reg == ST_RUN);
        issue_tag.vld  = rd_en;
        issue_tag.last = rd_en && (plane_reg == PW'(NUM_PLANES - 1));
    end

    always_comb
    begin
        state_next     = state_reg;
        plane_next     = plane_reg;
        pend_next      = pend_reg;
        inside_next    = inside_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    plane_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                plane_next = plane_reg + 1'b1;
                if (issue_tag.last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (res.done)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        inside_next    = res.hit;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        pend_next  = res.hit;
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    inside_next    = pend_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            out_valid_reg <= 1'b0;
            rd_tag_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            out_valid_reg <= out_valid_next;
            rd_tag_reg    <= issue_tag;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        inside_reg <= inside_next;
    end

    assign out_valid  = out_valid_reg;
    assign inside_res = inside_reg;

endmodule
